/* hdl/cvpl_pkg.sv */
// ----------------------------------------------------------------------------
// Column value at pressure level: shared definitions
// Widths, register indexes, reset values and the job record that the front
// hands to the back through the job queue.
// ----------------------------------------------------------------------------
package cvpl_pkg;

   localparam int VALUE_BITS    = 32;
   localparam int PRESSURE_BITS = 21;
   localparam int CSR_DATA_BITS = (VALUE_BITS > PRESSURE_BITS) ? VALUE_BITS : PRESSURE_BITS;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_PRESSURE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_VALUE      = CSR_INDEX_BITS'(1);

   localparam logic [PRESSURE_BITS-1:0] TARGET_RESET = PRESSURE_BITS'(800000);
   localparam logic [VALUE_BITS-1:0]    FILL_RESET   = VALUE_BITS'(64'h0000_0000_8000_0000);

   localparam int MAG_W  = VALUE_BITS + PRESSURE_BITS + 1;
   localparam int PROD_W = MAG_W + 1;
   localparam int SUM_W  = MAG_W + 2;
   localparam int CNT_W  = $clog2(MAG_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      JOB_FILL    = 2'd0,
      JOB_DIRECT  = 2'd1,
      JOB_BRACKET = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type              kind;
      logic [PRESSURE_BITS-1:0]  target;
      logic [PRESSURE_BITS-1:0]  lower_p;
      logic [PRESSURE_BITS-1:0]  upper_p;
      logic [VALUE_BITS-1:0]     lower_v;
      logic [VALUE_BITS-1:0]     upper_v;
      logic [VALUE_BITS-1:0]     direct_v;
   } job_type;

   typedef struct packed {
      logic busy;
      logic take;
   } back_status_type;

endpackage

/* hdl/column_value_at_pressure_level_unit.sv */
// ----------------------------------------------------------------------------
// Column value at pressure level
// Streams column levels and returns the field value at the target pressure,
// linearly interpolated between the bracketing levels, or the fill value.
//
//   Channel   Direction  Handshake         Payload
//   req_      in         push / full       level_pressure, level_value, last_level
//   rsp_      out        pop / empty       level_result, in_range
//   csr_      in         write             index, data (target, fill)
//
// The front end takes one level per cycle while the job queue is not full.
// Each column ends in one job for the back end; direct and fill results
// skip the bit-serial divider (one quotient bit per cycle over 54 bits)
// that interpolated ones use. A two-entry job queue lets the next columns
// stream in meanwhile; full rises once two jobs wait. Reset is synchronous.
// ----------------------------------------------------------------------------
module column_value_at_pressure_level_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [cvpl_pkg::PRESSURE_BITS-1:0]    req_level_pressure,
   input  logic [cvpl_pkg::VALUE_BITS-1:0]       req_level_value,
   input  logic                                  req_last_level,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [cvpl_pkg::VALUE_BITS-1:0]       rsp_level_result,
   output logic                                  rsp_in_range,
   input  logic                                  csr_write,
   input  logic [cvpl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cvpl_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import cvpl_pkg::*;

   logic [PRESSURE_BITS-1:0] target_ff;
   logic [VALUE_BITS-1:0]    fill_ff;
   logic                     job_push;
   job_type                  push_job;
   job_type                  pop_job;
   logic                     q_full;
   logic                     q_empty;
   logic                     q_pop;
   back_status_type          status;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         fill_ff   <= FILL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TARGET_PRESSURE: target_ff <= csr_data[PRESSURE_BITS-1:0];
            CSR_FILL_VALUE:      fill_ff   <= csr_data[VALUE_BITS-1:0];
            default: ;
         endcase
      end
   end

   cvpl_front u_front (
      .clock              (clock),
      .reset              (reset),
      .target             (target_ff),
      .fill               (fill_ff),
      .req_push           (req_push),
      .req_level_pressure (req_level_pressure),
      .req_level_value    (req_level_value),
      .req_last_level     (req_last_level),
      .q_full             (q_full),
      .job_push           (job_push),
      .job                (push_job)
   );

   cvpl_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .pop_job  (pop_job)
   );

   cvpl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .job              (pop_job),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_level_result (rsp_level_result),
      .rsp_in_range     (rsp_in_range),
      .status           (status)
   );

   assign req_full = q_full;

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      status.take |=> status.busy)
      else $error("back end did not start on a taken job");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !q_empty)
      else $error("job queue full and empty at once");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !status.busy) |=> rsp_empty)
      else $error("result appeared without back end work");

   a_take_when_idle: assert property (@(posedge clock) disable iff (reset)
      status.take |-> !status.busy && !q_empty)
      else $error("job taken while back end busy");

endmodule

/* hdl/cvpl_front.sv */
// ----------------------------------------------------------------------------
// Column value at pressure level: front end
// Takes one level per transaction, tracks the bracketing levels and, on the
// last level, classifies the column and emits a job.
// ----------------------------------------------------------------------------
module cvpl_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cvpl_pkg::PRESSURE_BITS-1:0]  target,
   input  logic [cvpl_pkg::VALUE_BITS-1:0]     fill,
   input  logic                                req_push,
   input  logic [cvpl_pkg::PRESSURE_BITS-1:0]  req_level_pressure,
   input  logic [cvpl_pkg::VALUE_BITS-1:0]     req_level_value,
   input  logic                                req_last_level,
   input  logic                                q_full,
   output logic                                job_push,
   output cvpl_pkg::job_type                   job
);
   import cvpl_pkg::*;

   logic                     accept;
   logic                     hit;
   logic [PRESSURE_BITS-1:0] first_eff;

   logic                     at_first_ff, at_first_in;
   logic                     found_ff, found_in;
   logic [PRESSURE_BITS-1:0] first_p_ff, first_p_in;
   logic [PRESSURE_BITS-1:0] prev_p_ff, prev_p_in;
   logic [VALUE_BITS-1:0]    prev_v_ff, prev_v_in;
   logic [PRESSURE_BITS-1:0] lower_p_ff, lower_p_in;
   logic [PRESSURE_BITS-1:0] upper_p_ff, upper_p_in;
   logic [VALUE_BITS-1:0]    lower_v_ff, lower_v_in;
   logic [VALUE_BITS-1:0]    upper_v_ff, upper_v_in;

   assign accept    = req_push & ~q_full;
   assign hit       = ~at_first_ff & ~found_ff & (req_level_pressure > target);
   assign first_eff = at_first_ff ? req_level_pressure : first_p_ff;

   always_comb begin
      first_p_in = at_first_ff ? req_level_pressure : first_p_ff;
      prev_p_in  = req_level_pressure;
      prev_v_in  = req_level_value;
      lower_p_in = hit ? prev_p_ff : lower_p_ff;
      lower_v_in = hit ? prev_v_ff : lower_v_ff;
      upper_p_in = hit ? req_level_pressure : upper_p_ff;
      upper_v_in = hit ? req_level_value : upper_v_ff;
      found_in   = req_last_level ? 1'b0 : (found_ff | hit);
      at_first_in = req_last_level;
   end

   always_comb begin
      job.target  = target;
      job.lower_p = lower_p_in;
      job.upper_p = upper_p_in;
      job.lower_v = lower_v_in;
      job.upper_v = upper_v_in;
      priority if ((target < first_eff) || (target > req_level_pressure)) begin
         job.kind     = JOB_FILL;
         job.direct_v = fill;
      end else if (!(found_ff | hit)) begin
         job.kind     = JOB_DIRECT;
         job.direct_v = req_level_value;
      end else begin
         job.kind     = JOB_BRACKET;
         job.direct_v = req_level_value;
      end
   end

   assign job_push = accept & req_last_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         at_first_ff <= 1'b1;
         found_ff    <= 1'b0;
         first_p_ff  <= '0;
         prev_p_ff   <= '0;
         prev_v_ff   <= '0;
         lower_p_ff  <= '0;
         upper_p_ff  <= '0;
         lower_v_ff  <= '0;
         upper_v_ff  <= '0;
      end else if (accept) begin
         at_first_ff <= at_first_in;
         found_ff    <= found_in;
         first_p_ff  <= first_p_in;
         prev_p_ff   <= prev_p_in;
         prev_v_ff   <= prev_v_in;
         lower_p_ff  <= lower_p_in;
         upper_p_ff  <= upper_p_in;
         lower_v_ff  <= lower_v_in;
         upper_v_ff  <= upper_v_in;
      end
   end

endmodule

/* hdl/cvpl_job_queue.sv */
// ----------------------------------------------------------------------------
// Column value at pressure level: job queue
// Two-entry queue of column jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module cvpl_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cvpl_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output cvpl_pkg::job_type pop_job
);
   import cvpl_pkg::*;

   job_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ((wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1)
                          : wr_ptr_ff;
      rd_ptr_in = do_pop ? ((rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1)
                         : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hdl/cvpl_back.sv */
// ----------------------------------------------------------------------------
// Column value at pressure level: back end
// Carries out one column job: multiply, restoring divide and saturating add
// for an interpolated job, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cvpl_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  cvpl_pkg::job_type                job,
   output logic                             q_pop,
   input  logic                             rsp_pop,
   output logic                             rsp_empty,
   output logic [cvpl_pkg::VALUE_BITS-1:0]  rsp_level_result,
   output logic                             rsp_in_range,
   output cvpl_pkg::back_status_type        status
);
   import cvpl_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SETUP = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_ABS   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_SUM   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   job_type                   job_ff;
   logic signed [VALUE_BITS:0]    dy_ff;
   logic signed [PRESSURE_BITS:0] dp_ff;
   logic [PRESSURE_BITS-1:0]  span_ff;
   logic [VALUE_BITS-1:0]     base_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      neg_ff;
   logic [MAG_W-1:0]          quo_ff;
   logic [PRESSURE_BITS-1:0]  rem_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [VALUE_BITS-1:0]     res_ff;
   logic                      rng_ff;
   logic                      out_valid_ff;
   logic [VALUE_BITS-1:0]     out_value_ff;
   logic                      out_range_ff;

   logic signed [PRESSURE_BITS:0] span_s;
   logic signed [PRESSURE_BITS:0] dp_s;
   logic signed [VALUE_BITS:0]    dy_s;
   logic signed [PROD_W-1:0]      prod_s;
   logic [PROD_W-1:0]             mag_s;
   logic [PRESSURE_BITS:0]        shifted;
   logic [PRESSURE_BITS:0]        diff;
   logic                          qbit;
   logic signed [SUM_W-1:0]       q_ext;
   logic signed [SUM_W-1:0]       base_ext;
   logic signed [SUM_W-1:0]       sum_s;
   logic [VALUE_BITS-1:0]         sat_s;
   logic                          out_free;

   assign span_s = $signed({1'b0, job_ff.upper_p}) - $signed({1'b0, job_ff.lower_p});
   assign dp_s   = $signed({1'b0, job_ff.target}) - $signed({1'b0, job_ff.lower_p});
   assign dy_s   = $signed({job_ff.upper_v[VALUE_BITS-1], job_ff.upper_v})
                 - $signed({job_ff.lower_v[VALUE_BITS-1], job_ff.lower_v});
   assign prod_s = dy_ff * dp_ff;
   assign mag_s  = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);

   assign shifted = {rem_ff, quo_ff[MAG_W-1]};
   assign diff    = shifted - {1'b0, span_ff};
   assign qbit    = (shifted >= {1'b0, span_ff});

   assign q_ext    = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
   assign base_ext = $signed({{(SUM_W - VALUE_BITS){base_ff[VALUE_BITS-1]}}, base_ff});
   assign sum_s    = base_ext + q_ext;

   always_comb begin
      if (&sum_s[SUM_W-1:VALUE_BITS-1] || ~|sum_s[SUM_W-1:VALUE_BITS-1]) begin
         sat_s = sum_s[VALUE_BITS-1:0];
      end else if (sum_s[SUM_W-1]) begin
         sat_s = {1'b1, {(VALUE_BITS - 1){1'b0}}};
      end else begin
         sat_s = {1'b0, {(VALUE_BITS - 1){1'b1}}};
      end
   end

   assign out_free = ~out_valid_ff | rsp_pop;
   assign q_pop    = (state_ff == ST_IDLE) & ~q_empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if ((job_ff.kind == JOB_BRACKET) && !(span_s[PRESSURE_BITS] || (span_s == '0))) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_MUL: state_in = ST_ABS;
         ST_ABS: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(1)) state_in = ST_SUM;
         end
         ST_SUM: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_OUT) && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= job;
      end
      unique case (state_ff)
         ST_SETUP: begin
            dy_ff   <= dy_s;
            dp_ff   <= dp_s;
            span_ff <= span_s[PRESSURE_BITS-1:0];
            base_ff <= job_ff.lower_v;
            unique case (job_ff.kind)
               JOB_FILL: begin
                  res_ff <= job_ff.direct_v;
                  rng_ff <= 1'b0;
               end
               JOB_DIRECT: begin
                  res_ff <= job_ff.direct_v;
                  rng_ff <= 1'b1;
               end
               default: begin
                  res_ff <= job_ff.lower_v;
                  rng_ff <= 1'b1;
               end
            endcase
         end
         ST_MUL: prod_ff <= prod_s;
         ST_ABS: begin
            neg_ff <= prod_ff[PROD_W-1];
            quo_ff <= mag_s[MAG_W-1:0];
            rem_ff <= '0;
            cnt_ff <= CNT_W'(MAG_W);
         end
         ST_DIV: begin
            rem_ff <= qbit ? diff[PRESSURE_BITS-1:0] : shifted[PRESSURE_BITS-1:0];
            quo_ff <= {quo_ff[MAG_W-2:0], qbit};
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_SUM: res_ff <= sat_s;
         ST_OUT: begin
            if (out_free) begin
               out_value_ff <= res_ff;
               out_range_ff <= rng_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_level_result = out_value_ff;
   assign rsp_in_range     = out_range_ff;
   assign status.busy      = (state_ff != ST_IDLE);
   assign status.take      = q_pop;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the column value at pressure level unit
// Streams pressure columns into the unit through its queue-style ports.
// Directed columns cover the corners, and random columns follow around
// several target and fill settings. A predictor computes the value that is
// due at each column end. A checker compares every result transaction with
// the oldest prediction, and a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb;
   import cvpl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_PRESSURE = (1 << PRESSURE_BITS) - 1;
   localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
   localparam longint VALUE_MIN = -VALUE_MAX - 1;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT = 5000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [VALUE_BITS-1:0] level_result;
      logic                  in_range;
   } column_result_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [PRESSURE_BITS-1:0]  req_level_pressure = '0;
   logic [VALUE_BITS-1:0]     req_level_value = '0;
   logic                      req_last_level = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [VALUE_BITS-1:0]     rsp_level_result;
   logic                      rsp_in_range;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   column_result_type pending_results[$];
   int failures = 0;
   int pop_stall = 0;
   int quiet_cycles = 0;
   logic idle_on = 1'b1;

   logic [PRESSURE_BITS-1:0] cfg_target = TARGET_RESET;
   logic [VALUE_BITS-1:0]    cfg_fill = FILL_RESET;
   logic [PRESSURE_BITS-1:0] col_first_p = '0;
   logic [PRESSURE_BITS-1:0] col_prev_p = '0;
   logic [VALUE_BITS-1:0]    col_prev_v = '0;
   logic                     col_start = 1'b1;
   logic                     col_bracketed = 1'b0;
   logic [PRESSURE_BITS-1:0] brk_lo_p = '0;
   logic [PRESSURE_BITS-1:0] brk_hi_p = '0;
   logic [VALUE_BITS-1:0]    brk_lo_v = '0;
   logic [VALUE_BITS-1:0]    brk_hi_v = '0;

   column_value_at_pressure_level_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_level_pressure (req_level_pressure),
      .req_level_value    (req_level_value),
      .req_last_level     (req_last_level),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_level_result   (rsp_level_result),
      .rsp_in_range       (rsp_in_range),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endfunction

   // Tracks the bracket as levels stream in and predicts the column result.
   function automatic void track_level(logic [PRESSURE_BITS-1:0] p,
                                       logic [VALUE_BITS-1:0] v, logic last);
      column_result_type res;
      longint span;
      longint dp;
      longint est;
      if (col_start) begin
         col_first_p = p;
      end else if (!col_bracketed && p > cfg_target) begin
         col_bracketed = 1'b1;
         brk_lo_p = col_prev_p;
         brk_lo_v = col_prev_v;
         brk_hi_p = p;
         brk_hi_v = v;
      end
      col_prev_p = p;
      col_prev_v = v;
      col_start = 1'b0;
      if (last) begin
         res.in_range = 1'b1;
         if (cfg_target < col_first_p || cfg_target > p) begin
            res.level_result = cfg_fill;
            res.in_range = 1'b0;
         end else if (!col_bracketed) begin
            res.level_result = v;
         end else begin
            span = longint'(brk_hi_p) - longint'(brk_lo_p);
            dp = longint'(cfg_target) - longint'(brk_lo_p);
            if (span <= 0) begin
               res.level_result = brk_lo_v;
            end else begin
               est = longint'(signed'(brk_lo_v)) +
                     (longint'(signed'(brk_hi_v)) - longint'(signed'(brk_lo_v))) * dp / span;
               if (est > VALUE_MAX) est = VALUE_MAX;
               if (est < VALUE_MIN) est = VALUE_MIN;
               res.level_result = est[VALUE_BITS-1:0];
            end
         end
         pending_results.push_back(res);
         col_start = 1'b1;
         col_bracketed = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               CSR_TARGET_PRESSURE: cfg_target = csr_data[PRESSURE_BITS-1:0];
               CSR_FILL_VALUE:      cfg_fill = csr_data[VALUE_BITS-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full)
            track_level(req_level_pressure, req_level_value, req_last_level);
      end
   end

   always @(posedge clock) begin
      column_result_type due;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("transaction with no result due: %h/%b",
                                   rsp_level_result, rsp_in_range));
         end else begin
            due = pending_results.pop_front();
            if (rsp_level_result !== due.level_result || rsp_in_range !== due.in_range)
               note_failure($sformatf("result mismatch: expected %h/%b, got %h/%b",
                                      due.level_result, due.in_range,
                                      rsp_level_result, rsp_in_range));
         end
      end
   end

   always @(posedge clock) begin
      if (pop_stall > 0) begin
         pop_stall--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         if ($urandom_range(0, 3) == 0) pop_stall = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // The push stays high across back-to-back levels, it only drops for a gap or while waiting for results.
   task automatic send_level(input int unsigned p, input logic [VALUE_BITS-1:0] v,
                             input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_level_pressure <= PRESSURE_BITS'(p);
      req_level_value <= v;
      req_last_level <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic wait_for_results(input logic settle);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_registers();
      send_level(700000, 32'h0001_0000, 1'b0);
      send_level(900000, 32'h0003_0000, 1'b1);
      send_level(900000, 32'h1234_5678, 1'b1);
   endtask

   task automatic test_column_edges();
      wait_for_results(1'b1);
      write_csr(CSR_TARGET_PRESSURE, 32'hFFE0_0000);
      send_level(0, 32'h7FFF_FFFF, 1'b1);
      send_level(0, 32'h8000_0000, 1'b0);
      send_level(MAX_PRESSURE, 32'h7FFF_FFFF, 1'b1);
      wait_for_results(1'b1);
      write_csr(CSR_TARGET_PRESSURE, MAX_PRESSURE);
      send_level(0, 32'h0000_0001, 1'b0);
      send_level(MAX_PRESSURE, 32'hFFFF_FFFE, 1'b1);
      send_level(5, 32'h0000_0000, 1'b1);
      wait_for_results(1'b1);
      write_csr(CSR_TARGET_PRESSURE, 1000);
      write_csr(CSR_FILL_VALUE, 32'h7FFF_FFFF);
      send_level(2000, 32'h0001_0000, 1'b0);
      send_level(3000, 32'h0002_0000, 1'b1);
      wait_for_results(1'b1);
      write_csr(CSR_FILL_VALUE, 32'h0000_0000);
      send_level(500, 32'h8000_0000, 1'b0);
      send_level(1500, 32'h7FFF_FFFF, 1'b1);
      send_level(500, 32'h7FFF_FFFF, 1'b0);
      send_level(1500, 32'h8000_0000, 1'b1);
      send_level(100, 32'h0000_1000, 1'b0);
      send_level(5000, 32'hFFFF_0000, 1'b0);
      send_level(50, 32'h0042_0000, 1'b0);
      send_level(3000, 32'h0010_0000, 1'b1);
   endtask

   task automatic test_target_moves_mid_column();
      wait_for_results(1'b1);
      write_csr(CSR_TARGET_PRESSURE, 50);
      send_level(100, 32'h0005_0000, 1'b0);
      send_level(100, 32'h0006_0000, 1'b0);
      wait_for_results(1'b1);
      write_csr(CSR_TARGET_PRESSURE, 100);
      send_level(200, 32'h0007_0000, 1'b1);
      wait_for_results(1'b1);
      write_csr(CSR_TARGET_PRESSURE, 5);
      send_level(0, 32'h0000_0000, 1'b0);
      send_level(10, 32'h7FFF_0000, 1'b0);
      wait_for_results(1'b1);
      write_csr(CSR_TARGET_PRESSURE, 2000000);
      send_level(MAX_PRESSURE, 32'h8000_0000, 1'b1);
   endtask

   // Most columns are ascending and gathered around the target, the rest are
   // out of range, hit the target exactly, or are not sorted at all.
   task automatic test_random_columns();
      int unsigned prs[$];
      logic [VALUE_BITS-1:0] vals[$];
      logic [VALUE_BITS-1:0] fill;
      int unsigned lo, hi, radius, step, p, t;
      int n, kind, phase_levels, columns;
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_results(1'b1);
         case (phase)
            0:       t = 0;
            1:       t = MAX_PRESSURE;
            default: t = $urandom_range(0, MAX_PRESSURE);
         endcase
         write_csr(CSR_TARGET_PRESSURE, ($urandom & ~MAX_PRESSURE) | t);
         case (phase)
            0:       fill = 32'h8000_0000;
            1:       fill = 32'h7FFF_FFFF;
            default: fill = $urandom;
         endcase
         write_csr(CSR_FILL_VALUE, fill);
         idle_on = (phase != 3);
         phase_levels = 0;
         columns = 0;
         while (phase_levels < 210) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
            kind = $urandom_range(0, 9);
            case ($urandom_range(0, 3))
               0:       radius = 16;
               1:       radius = 4096;
               2:       radius = 1 << 18;
               default: radius = MAX_PRESSURE;
            endcase
            lo = (t > radius) ? t - radius : 0;
            hi = (MAX_PRESSURE - t > radius) ? t + radius : MAX_PRESSURE;
            if (kind == 8) begin
               if (t < MAX_PRESSURE) lo = t + 1;
               else hi = t - 1;
            end
            prs.delete();
            vals.delete();
            step = (hi - lo) / n + 1;
            p = lo + $urandom_range(0, step - 1);
            for (int i = 0; i < n; i++) begin
               if (kind == 9) p = $urandom_range(0, MAX_PRESSURE);
               if (p > hi) p = hi;
               prs.push_back(p);
               vals.push_back($urandom);
               p = p + $urandom_range(0, 2 * step);
            end
            if (kind == 7) prs[$urandom_range(0, n - 1)] = t;
            foreach (prs[i]) send_level(prs[i], vals[i], i == n - 1);
            phase_levels += n;
            columns++;
            if (phase == 2 && columns == 20) wait_for_results(1'b0);
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_registers();
      test_column_edges();
      test_target_moves_mid_column();
      test_random_columns();
      wait_for_results(1'b1);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* column_value_at_pressure_level_unit.f */
hdl/cvpl_pkg.sv
hdl/cvpl_front.sv
hdl/cvpl_job_queue.sv
hdl/cvpl_back.sv
hdl/column_value_at_pressure_level_unit.sv
tb/tb.sv
